// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the seven-segment display driver
// Holds the command codes, the classified operation type, the queue entry
// and the digit-to-segment decoder that the front and back parts both use.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [1:0] CMD_CLEAR     = 2'd0;
  localparam logic [1:0] CMD_SET_DIGIT = 2'd1;
  localparam logic [1:0] CMD_SET_VALUE = 2'd2;
  localparam logic [1:0] CMD_REFRESH   = 2'd3;

  // Slot store layout: enable bit above the seven segment bits.
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned ENTRY_W  = SEG_W + 1;
  localparam int unsigned VALUE_W  = 16;

  // Reciprocal of ten for a 16-bit dividend: q = (v * 52429) >> 19.
  localparam logic [VALUE_W-1:0] RECIP_TEN = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  // Operation after classification in the front part.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SET_DIGIT,
    OP_SET_VALUE,
    OP_REFRESH
  } op_t;

  // One queued item handed from the front part to the back part.
  typedef struct packed {
    op_t                op;
    logic [1:0]         index;
    logic [SEG_W-1:0]   seg;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VALUE,
    ST_SCAN
  } state_t;

  // Decimal digit to lit segments (bit0 = a .. bit6 = g); above nine shows 9.
  function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7C;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      default: seg = 7'h67;
    endcase
    return seg;
  endfunction

endpackage

// ===== rtl/ssd_front.sv =====
// ----------------------------------------------------------------------------
// ssd_front: command intake and classification
// Accepts input items, decodes segments, saturates values, turns commands
// that change nothing into no-ops, and holds the result in a two-entry queue.
// ----------------------------------------------------------------------------
module ssd_front #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [1:0]                  digit_index,
  input  logic [3:0]                  digit_value,
  input  logic [ssd_pkg::VALUE_W-1:0] value,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output ssd_pkg::cmd_t               cmd
);

  localparam longint unsigned MAX_VALUE = (10 ** NUM_DIGITS) - 1;

  ssd_pkg::cmd_t              entry;
  ssd_pkg::cmd_t              queue [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 count;
  logic                       push;
  logic                       pop;
  logic [ssd_pkg::VALUE_W-1:0] sat_value;

  // Saturate the value to the largest number the slots can show.
  always_comb begin
    if (64'(value) > MAX_VALUE) begin
      sat_value = ssd_pkg::VALUE_W'(MAX_VALUE);
    end else begin
      sat_value = value;
    end
  end

  // Classify the item; commands with no effect become no-ops.
  always_comb begin
    entry.index = digit_index;
    entry.seg   = ssd_pkg::seg_decode(digit_value);
    entry.value = sat_value;
    case (command)
      ssd_pkg::CMD_CLEAR: begin
        entry.op = ssd_pkg::OP_CLEAR;
      end
      ssd_pkg::CMD_SET_DIGIT: begin
        if (32'(digit_index) < NUM_DIGITS) begin
          entry.op = ssd_pkg::OP_SET_DIGIT;
        end else begin
          entry.op = ssd_pkg::OP_NONE;
        end
      end
      ssd_pkg::CMD_SET_VALUE: begin
        if (value != '0) begin
          entry.op = ssd_pkg::OP_SET_VALUE;
        end else begin
          entry.op = ssd_pkg::OP_NONE;
        end
      end
      default: begin
        entry.op = ssd_pkg::OP_REFRESH;
      end
    endcase
  end

  // Two-entry queue between intake and execution.
  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

endmodule

// ===== rtl/ssd_back.sv =====
// ----------------------------------------------------------------------------
// ssd_back: slot store and command execution
// Holds the digit slots, converts values one decimal digit per cycle, and scans
// them one per cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module ssd_back #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  ssd_pkg::cmd_t             cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                digit_select,
  output logic [ssd_pkg::SEG_W-1:0] segments_n,
  output logic                      last
);

  localparam int unsigned SLOT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_DIGITS - 1);

  ssd_pkg::state_t              state;
  ssd_pkg::state_t              state_next;
  logic [ssd_pkg::ENTRY_W-1:0]  store [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]        en_vec;
  logic [NUM_DIGITS-1:0]        en_shift;
  logic [SLOT_W-1:0]            slot;
  logic [SLOT_W-1:0]            slot_next;
  logic [ssd_pkg::VALUE_W-1:0]  work;
  logic [ssd_pkg::VALUE_W-1:0]  work_next;
  logic [31:0]                  prod;
  logic [ssd_pkg::VALUE_W-1:0]  quot;
  logic [ssd_pkg::VALUE_W-1:0]  quot_ten;
  logic [3:0]                   rem;
  logic                         clear_all;
  logic                         wr_en;
  logic [SLOT_W-1:0]            wr_slot;
  logic [ssd_pkg::SEG_W-1:0]    wr_seg;
  logic                         out_free;
  logic                         slot_en;
  logic                         emit;
  logic                         advance;
  logic                         later_en;

  // Enable bits of all slots, used for the last-digit flag.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      en_vec[i] = store[i][ssd_pkg::ENTRY_W-1];
    end
  end

  assign en_shift = en_vec >> slot;
  assign later_en = |(en_shift >> 1);
  assign slot_en  = store[slot][ssd_pkg::ENTRY_W-1];
  assign out_free = !out_valid || out_ready;

  // One decimal digit per cycle: quotient by reciprocal, remainder by subtract.
  assign prod     = 32'(work) * 32'(ssd_pkg::RECIP_TEN);
  assign quot     = ssd_pkg::VALUE_W'(prod >> ssd_pkg::RECIP_SHIFT);
  assign quot_ten = (quot << 3) + (quot << 1);
  assign rem      = 4'(work - quot_ten);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ssd_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == ssd_pkg::OP_SET_VALUE) begin
            state_next = ssd_pkg::ST_VALUE;
          end else if (cmd.op == ssd_pkg::OP_REFRESH) begin
            state_next = ssd_pkg::ST_SCAN;
          end
        end
      end
      ssd_pkg::ST_VALUE: begin
        if (quot == '0 || slot == '0) begin
          state_next = ssd_pkg::ST_IDLE;
        end
      end
      ssd_pkg::ST_SCAN: begin
        if (advance && slot == LAST_SLOT) begin
          state_next = ssd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ssd_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: store writes, counters and output loads.
  always_comb begin
    cmd_ready = 1'b0;
    clear_all = 1'b0;
    wr_en     = 1'b0;
    wr_slot   = slot;
    wr_seg    = ssd_pkg::seg_decode(rem);
    emit      = 1'b0;
    advance   = 1'b0;
    slot_next = slot;
    work_next = work;
    case (state)
      ssd_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.op)
            ssd_pkg::OP_CLEAR: begin
              clear_all = 1'b1;
            end
            ssd_pkg::OP_SET_DIGIT: begin
              wr_en   = 1'b1;
              wr_slot = SLOT_W'(cmd.index);
              wr_seg  = cmd.seg;
            end
            ssd_pkg::OP_SET_VALUE: begin
              slot_next = LAST_SLOT;
              work_next = cmd.value;
            end
            ssd_pkg::OP_REFRESH: begin
              slot_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ssd_pkg::ST_VALUE: begin
        wr_en     = 1'b1;
        work_next = quot;
        if (slot != '0) begin
          slot_next = slot - 1'b1;
        end
      end
      ssd_pkg::ST_SCAN: begin
        // A disabled slot is skipped; an enabled one waits for a free output.
        advance = !slot_en || out_free;
        emit    = slot_en && out_free;
        if (advance && slot != LAST_SLOT) begin
          slot_next = slot + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers and slot store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssd_pkg::ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        store[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (clear_all) begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          store[i] <= '0;
        end
      end else if (wr_en) begin
        store[wr_slot] <= {1'b1, wr_seg};
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    slot <= slot_next;
    work <= work_next;
    if (emit) begin
      digit_select <= 2'(slot);
      segments_n   <= ~store[slot][ssd_pkg::SEG_W-1:0];
      last         <= !later_en;
    end
  end

  // A clear leaves every slot disabled.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ssd_pkg::ST_IDLE && cmd_valid && cmd.op == ssd_pkg::OP_CLEAR)
    |=> (en_vec == '0))
    else $error("slots still enabled after clear");

  // A set-digit enables the addressed slot.
  a_set_enables: assert property (@(posedge clk) disable iff (rst)
    (state == ssd_pkg::ST_IDLE && cmd_valid && cmd.op == ssd_pkg::OP_SET_DIGIT)
    |=> en_vec[SLOT_W'($past(cmd.index))])
    else $error("set-digit did not enable its slot");

  // The conversion loop only runs on a nonzero remainder of the value.
  a_value_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ssd_pkg::ST_VALUE) |-> (work != '0))
    else $error("digit conversion running on zero");

  // A scan ends once the final slot has been handled.
  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ssd_pkg::ST_SCAN && advance && slot == LAST_SLOT)
    |=> (state == ssd_pkg::ST_IDLE))
    else $error("scan did not finish after the final slot");

endmodule

// ===== rtl/four_digit_seven_segment_driver.sv =====
// ----------------------------------------------------------------------------
// four_digit_seven_segment_driver: multiplexed seven-segment display driver
// Keeps digit slots, takes clear, set-digit, set-value and refresh commands,
// and returns one active-low segment word per enabled slot on refresh.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready   command, digit_index,
//                                             digit_value, value
//   out      output     out_valid / out_ready digit_select, segments_n, last
//
// A command is held in the queue until the sequencer is idle; dispatch alone
// carries out clear and set-digit. Set-value then writes one decimal digit per
// divide-by-ten step, up to NUM_DIGITS digits, from the last slot down; refresh
// then scans the slots in order, one per cycle unless the output stalls.
// Synchronous reset empties the queue, the output stage and all slots.
// A stalled output holds the scan at the current enabled slot; a full queue
// stalls the input.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_driver #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [1:0]                  digit_index,
  input  logic [3:0]                  digit_value,
  input  logic [ssd_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  digit_select,
  output logic [ssd_pkg::SEG_W-1:0]   segments_n,
  output logic                        last
);

  logic          cmd_valid;
  logic          cmd_ready;
  ssd_pkg::cmd_t cmd;

  // Intake, classification and command queue.
  ssd_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .digit_index (digit_index),
    .digit_value (digit_value),
    .value       (value),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  // Slot store, conversion and scan.
  ssd_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_select (digit_select),
    .segments_n   (segments_n),
    .last         (last)
  );

endmodule
